[src/ostm_pkg.sv]
// ----------------------------------------------------------------------------
// ostm_pkg
// shared types and constants of the overspeed trip monitor
// ----------------------------------------------------------------------------
`default_nettype none

package ostm_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned FactorW = 8;
  localparam int unsigned ProdW   = CountW + FactorW;
  localparam int unsigned StepW   = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [StepW-1:0] LastStep = StepW'(ProdW - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgTeethCount    = 3'd0,
    CfgRpmScale      = 3'd1,
    CfgCountMin      = 3'd2,
    CfgCountMax      = 3'd3,
    CfgOverspeedLim  = 3'd4,
    CfgTripDelay     = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OpWindow = 1'b0,
    OpReset  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StFin
  } state_e;

endpackage

`default_nettype wire

[src/overspeed_trip_monitor_top.sv]
// ----------------------------------------------------------------------------
// overspeed_trip_monitor_top
// tachometer overspeed trip relay with a bit-serial speed divider
// ----------------------------------------------------------------------------
// input channel: in_valid_i/in_ready_o with operation_i and pulse_count_i;
// a window item (operation 0) computes the speed, a reset item (operation 1)
// may release a latched trip. every item yields exactly one result item on
// out_valid_o/out_ready_i carrying speed_rpm_o, relay_on_o and status_led_o.
// a window item passes from the idle state that takes it to the count *
// rpm_scale multiply, the restoring divider (one quotient bit a cycle
// through a shared subtractor) and a final step that updates the trip
// state; a reset item goes from the idle state straight to the final step.
// the block takes one item at a time.
// the result register is separate from the working registers, so the next item
// is accepted while a result waits; the final update step holds until the
// result register is free when the receiver stalls.
// reset loads the register defaults (teeth 1, scale 60, min 60, max 65535,
// limit 65535, delay 3) and clears speed, delay count, arm, trip and indicator.
// configuration writes on cfg_we_i take effect at once; indexes 6 and 7 are
// ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module overspeed_trip_monitor_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [ostm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [ostm_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              operation_i,
  input  wire  [ostm_pkg::CountW-1:0]      pulse_count_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [ostm_pkg::CountW-1:0]      speed_rpm_o,
  output logic                             relay_on_o,
  output logic                             status_led_o
);
  import ostm_pkg::*;

  logic [FactorW-1:0] teeth_q, rpm_scale_q, trip_delay_q;
  logic [CountW-1:0]  count_min_q, count_max_q, limit_q;

  state_e             state_q, state_d;
  logic               op_q;
  logic [CountW-1:0]  cnt_q;
  logic [ProdW-1:0]   quo_q;
  logic [FactorW-1:0] rem_q;
  logic [StepW-1:0]   step_q;
  logic [FactorW-1:0] delay_q;
  logic               armed_q;
  logic               out_valid_q;
  logic [CountW-1:0]  speed_q;
  logic               tripped_q, led_q;

  logic               accept;
  logic               slot_free;
  logic               fin_go;
  logic [FactorW-1:0] teeth_eff;
  logic [ProdW-1:0]   prod;
  logic [FactorW:0]   trial;
  logic               qbit;
  logic [FactorW:0]   trial_diff;
  logic [CountW-1:0]  speed_new;
  logic               low_win;
  logic               over;
  logic [FactorW-1:0] delay_inc;
  logic [FactorW-1:0] delay_d;
  logic               armed_d;
  logic               tripped_d;
  logic               led_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      teeth_q      <= 8'd1;
      rpm_scale_q  <= 8'd60;
      count_min_q  <= 16'd60;
      count_max_q  <= 16'hFFFF;
      limit_q      <= 16'hFFFF;
      trip_delay_q <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTeethCount:   teeth_q      <= cfg_data_i[FactorW-1:0];
        CfgRpmScale:     rpm_scale_q  <= cfg_data_i[FactorW-1:0];
        CfgCountMin:     count_min_q  <= cfg_data_i;
        CfgCountMax:     count_max_q  <= cfg_data_i;
        CfgOverspeedLim: limit_q      <= cfg_data_i;
        CfgTripDelay:    trip_delay_q <= cfg_data_i[FactorW-1:0];
        default: ;
      endcase
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign fin_go    = (state_q == StFin) && slot_free;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (operation_i == OpReset) ? StFin : StMul;
        end
      end
      StMul: state_d = StDiv;
      StDiv: begin
        if (step_q == LastStep) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // multiply and shared divider step
  assign teeth_eff  = (teeth_q == '0) ? FactorW'(1) : teeth_q;
  assign prod       = ProdW'(cnt_q) * ProdW'(rpm_scale_q);
  assign trial      = {rem_q, quo_q[ProdW-1]};
  assign qbit       = trial >= {1'b0, teeth_eff};
  assign trial_diff = trial - {1'b0, teeth_eff};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      cnt_q <= (pulse_count_i <= count_min_q || pulse_count_i >= count_max_q)
               ? '0 : pulse_count_i;
    end
    if (state_q == StMul) begin
      quo_q  <= prod;
      rem_q  <= '0;
      step_q <= '0;
    end else if (state_q == StDiv) begin
      quo_q  <= {quo_q[ProdW-2:0], qbit};
      rem_q  <= qbit ? trial_diff[FactorW-1:0] : trial[FactorW-1:0];
      step_q <= step_q + StepW'(1);
    end
  end

  // trip state update
  assign speed_new = (quo_q[ProdW-1:CountW] != '0) ? '1 : quo_q[CountW-1:0];
  // exact quotient at or below count_min
  assign low_win   = (quo_q < ProdW'(count_min_q)) ||
                     ((quo_q == ProdW'(count_min_q)) && (rem_q == '0));
  assign over      = speed_new >= limit_q;
  assign delay_inc = over ? delay_q + FactorW'(1) : delay_q;

  always_comb begin
    delay_d   = delay_inc;
    armed_d   = armed_q;
    tripped_d = tripped_q;
    led_d     = low_win ? !led_q : 1'b1;
    if (delay_inc >= trip_delay_q) begin
      armed_d = 1'b1;
      delay_d = '0;
    end
    if (over && armed_d) begin
      tripped_d = 1'b1;
      armed_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= '0;
      armed_q     <= 1'b0;
      tripped_q   <= 1'b0;
      led_q       <= 1'b0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
        if (op_q == OpWindow) begin
          speed_q   <= speed_new;
          delay_q   <= delay_d;
          armed_q   <= armed_d;
          tripped_q <= tripped_d;
          led_q     <= led_d;
        end else if (speed_q < limit_q) begin
          tripped_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // state registers change only when a new result is loaded
  assign out_valid_o  = out_valid_q;
  assign speed_rpm_o  = speed_q;
  assign relay_on_o   = tripped_q;
  assign status_led_o = led_q;

endmodule

`default_nettype wire

[src/ostm_checker.sv]
// ----------------------------------------------------------------------------
// ostm_checker
// port-level checks of the overspeed trip monitor
// ----------------------------------------------------------------------------
`default_nettype none

module ostm_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_o,
  input wire                          operation_i,
  input wire                          out_valid_o,
  input wire                          out_ready_i,
  input wire [ostm_pkg::CountW-1:0]   speed_rpm_o
);
  import ostm_pkg::*;

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // reset item result after the final step, with no multiply or divider pass
  a_reset_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i && !out_valid_o |-> ##2 out_valid_o)
    else $error("reset item result late");

  // window item result after the divider pass
  a_window_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !operation_i && !out_valid_o |-> ##27 out_valid_o)
    else $error("window item result late");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(speed_rpm_o))
    else $error("stalled result changed");

endmodule

bind overspeed_trip_monitor_top ostm_checker u_ostm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .operation_i (operation_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .speed_rpm_o (speed_rpm_o)
);

`default_nettype wire
